// ===== sv/sync_header_frame_receiver_defines.svh =====
// Assertion macros used by the checker of the frame receiver
`ifndef SYNC_HEADER_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_HEADER_FRAME_RECEIVER_DEFINES_SVH

// Clocked assertion, off while reset is asserted
`define SHFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("frame receiver assertion failed");

// Clocked assertion that also runs through reset
`define SHFR_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("frame receiver reset assertion failed");

`endif

// ===== sv/shfr_pkg.sv =====
// Types and constants shared by the frame receiver modules
`timescale 1ns / 1ps
`default_nettype none

package shfr_pkg;

    localparam int FRAME_DEPTH = 256;
    localparam int CQ_DEPTH    = 4;   // command queue depth, power of two
    localparam int CQ_AW       = $clog2(CQ_DEPTH);
    localparam int RQ_DEPTH    = 2;   // result queue depth, power of two
    localparam int RQ_AW       = $clog2(RQ_DEPTH);

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] MIN_LENGTH = 8'd2;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_TAKE = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       frame_ready;
        logic       frame_captured;
        logic       frame_dropped;
        logic [7:0] frame_length;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_READ = 2'd1,
        CMD_TAKE = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd_kind;

    // One classified word handed from the parser to the frame engine
    typedef struct packed {
        t_cmd_kind  kind;
        logic       wr_en;   // store data at addr in the receive buffer
        logic [7:0] addr;    // buffer position, or store position for a read
        logic [7:0] data;
        logic       done;    // this byte completes a frame
        logic [7:0] len;     // frame byte count when done
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_READ = 3'b010,
        BS_COPY = 3'b100
    } t_back_state;

endpackage

`default_nettype wire

// ===== sv/shfr_front.sv =====
// Header search and frame parser: turns input words into engine commands
`timescale 1ns / 1ps
`default_nettype none

module shfr_front import shfr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_word i_in_word,
    output t_cmd     o_cmd
);

    logic       r_hdr, n_hdr;
    logic       r_in_frame, n_in_frame;
    logic [7:0] r_idx, n_idx;
    logic [7:0] r_len_fld, n_len_fld;

    logic       hdr_a, inf_a, inf_b, wr, done;
    logic [7:0] idx_a, idx_b, lf_b;

    always_comb begin
        hdr_a = r_hdr;
        inf_a = r_in_frame;
        idx_a = r_idx;
        if (!r_in_frame) begin
            if (i_in_word.data_byte == SYNC_BYTE) begin
                if (r_hdr) begin
                    hdr_a = 1'b0;
                    inf_a = 1'b1;
                    idx_a = 8'd1;
                end else begin
                    hdr_a = 1'b1;
                end
            end else begin
                hdr_a = 1'b0;
                inf_a = 1'b0;
                idx_a = 8'd0;
            end
        end

        lf_b  = r_len_fld;
        inf_b = inf_a;
        idx_b = idx_a;
        wr    = 1'b0;
        done  = 1'b0;
        if (inf_a) begin
            wr = 1'b1;
            if (idx_a == 8'd2) begin
                lf_b = i_in_word.data_byte;
                // short length: clamp and abandon the frame
                if (i_in_word.data_byte < MIN_LENGTH) begin
                    lf_b  = MIN_LENGTH;
                    inf_b = 1'b0;
                end
            end
            idx_b = idx_a + 8'd1;
            if ({1'b0, idx_b} == ({1'b0, lf_b} + {1'b0, MIN_LENGTH})) begin
                done  = 1'b1;
                inf_b = 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd.wr_en = 1'b0;
        o_cmd.addr  = i_in_word.read_index;
        o_cmd.data  = i_in_word.data_byte;
        o_cmd.done  = 1'b0;
        o_cmd.len   = idx_b;
        unique case (i_in_word.op)
            OP_BYTE: begin
                o_cmd.kind  = CMD_BYTE;
                o_cmd.wr_en = wr;
                o_cmd.addr  = idx_a;
                o_cmd.done  = done;
            end
            OP_READ: o_cmd.kind = CMD_READ;
            OP_TAKE: o_cmd.kind = CMD_TAKE;
            default: o_cmd.kind = CMD_NOP;
        endcase
    end

    always_comb begin
        n_hdr      = r_hdr;
        n_in_frame = r_in_frame;
        n_idx      = r_idx;
        n_len_fld  = r_len_fld;
        if (i_accept && (i_in_word.op == OP_BYTE)) begin
            n_hdr      = hdr_a;
            n_in_frame = inf_b;
            n_idx      = idx_b;
            n_len_fld  = lf_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr      <= 1'b0;
            r_in_frame <= 1'b0;
            r_idx      <= 8'd0;
            r_len_fld  <= MIN_LENGTH;
        end else begin
            r_hdr      <= n_hdr;
            r_in_frame <= n_in_frame;
            r_idx      <= n_idx;
            r_len_fld  <= n_len_fld;
        end
    end

endmodule

`default_nettype wire

// ===== sv/shfr_cmd_fifo.sv =====
// Short command queue between the parser and the frame engine
`timescale 1ns / 1ps
`default_nettype none

module shfr_cmd_fifo import shfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr, r_rd;
    logic [CQ_AW:0]   r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (CQ_AW + 1)'(CQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/shfr_back.sv =====
// Frame engine: receive buffer, frame store, ready flag and result queue
`timescale 1ns / 1ps
`default_nettype none

module shfr_back import shfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_empty,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_word o_out_word
);

    t_back_state r_state, n_state;
    logic        r_ready, n_ready;
    logic [7:0]  r_cap_len, n_cap_len;
    logic [7:0]  r_rd_idx, n_rd_idx;
    logic        r_cp_busy, n_cp_busy;
    logic [7:0]  r_cp_idx, n_cp_idx;

    logic [7:0]             rx_mem [FRAME_DEPTH];
    logic [7:0]             fs_mem [FRAME_DEPTH];
    logic [FRAME_DEPTH-1:0] r_rx_vld, r_fs_vld;
    logic [7:0]             r_rx_q, r_fs_q;
    logic                   r_rx_q_vld, r_fs_q_vld;

    logic       rx_we, rx_re, fs_we, fs_re;
    logic [7:0] rx_waddr, rx_wdata, rx_raddr, fs_waddr, fs_wdata, fs_raddr;

    t_out_word        r_res [RQ_DEPTH];
    logic [RQ_AW-1:0] r_res_wr, r_res_rd;
    logic [RQ_AW:0]   r_res_cnt;
    logic             res_room, res_push, res_pop;
    t_out_word        res_word;

    assign res_room  = (r_res_cnt != (RQ_AW + 1)'(RQ_DEPTH));
    assign o_empty   = (r_res_cnt == '0);
    assign o_out_word = r_res[r_res_rd];
    assign res_pop   = i_pop && !o_empty;
    assign o_cmd_pop = (r_state == BS_IDLE) && !i_cmd_empty && res_room;

    always_comb begin
        n_state   = r_state;
        n_ready   = r_ready;
        n_cap_len = r_cap_len;
        n_rd_idx  = r_rd_idx;
        n_cp_busy = 1'b0;
        n_cp_idx  = r_cp_idx;
        rx_we     = 1'b0;
        rx_waddr  = i_cmd.addr;
        rx_wdata  = i_cmd.data;
        rx_re     = 1'b0;
        rx_raddr  = r_rd_idx;
        fs_we     = 1'b0;
        fs_waddr  = r_cp_idx;
        fs_wdata  = r_rx_q_vld ? r_rx_q : 8'd0;
        fs_re     = 1'b0;
        fs_raddr  = i_cmd.addr;
        res_push  = 1'b0;
        res_word.read_byte      = 8'd0;
        res_word.frame_ready    = r_ready;
        res_word.frame_captured = 1'b0;
        res_word.frame_dropped  = 1'b0;
        res_word.frame_length   = r_cap_len;

        unique case (r_state)
            BS_IDLE: begin
                if (o_cmd_pop) begin
                    unique case (i_cmd.kind)
                        CMD_BYTE: begin
                            rx_we = i_cmd.wr_en;
                            if (i_cmd.done && !r_ready) begin
                                n_ready   = 1'b1;
                                n_cap_len = i_cmd.len;
                                n_rd_idx  = 8'd0;
                                n_state   = BS_COPY;
                            end else begin
                                res_push = 1'b1;
                                res_word.frame_dropped = i_cmd.done;
                            end
                        end
                        CMD_READ: begin
                            fs_re   = 1'b1;
                            n_state = BS_READ;
                        end
                        CMD_TAKE: begin
                            res_push = 1'b1;
                            n_ready  = 1'b0;
                        end
                        CMD_NOP: res_push = 1'b1;
                    endcase
                end
            end
            BS_READ: begin
                res_push = 1'b1;
                res_word.read_byte = r_fs_q_vld ? r_fs_q : 8'd0;
                n_state = BS_IDLE;
            end
            BS_COPY: begin
                // read one buffer byte a cycle, write it to the store in the cycle after
                if (r_rd_idx != r_cap_len) begin
                    rx_re     = 1'b1;
                    n_rd_idx  = r_rd_idx + 8'd1;
                    n_cp_busy = 1'b1;
                    n_cp_idx  = r_rd_idx;
                end
                fs_we = r_cp_busy;
                if ((r_rd_idx == r_cap_len) && !r_cp_busy) begin
                    res_push = 1'b1;
                    res_word.frame_ready    = 1'b0;
                    res_word.frame_captured = 1'b1;
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            rx_mem[rx_waddr] <= rx_wdata;
        end
        if (rx_re) begin
            r_rx_q     <= rx_mem[rx_raddr];
            r_rx_q_vld <= r_rx_vld[rx_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            fs_mem[fs_waddr] <= fs_wdata;
        end
        if (fs_re) begin
            r_fs_q     <= fs_mem[fs_raddr];
            r_fs_q_vld <= r_fs_vld[fs_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_res_wr] <= res_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_ready   <= 1'b0;
            r_cap_len <= 8'd0;
            r_rd_idx  <= 8'd0;
            r_cp_busy <= 1'b0;
            r_cp_idx  <= 8'd0;
            r_rx_vld  <= '0;
            r_fs_vld  <= '0;
            r_res_wr  <= '0;
            r_res_rd  <= '0;
            r_res_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_ready   <= n_ready;
            r_cap_len <= n_cap_len;
            r_rd_idx  <= n_rd_idx;
            r_cp_busy <= n_cp_busy;
            r_cp_idx  <= n_cp_idx;
            if (rx_we) begin
                r_rx_vld[rx_waddr] <= 1'b1;
            end
            if (fs_we) begin
                r_fs_vld[fs_waddr] <= 1'b1;
            end
            if (res_push) begin
                r_res_wr <= r_res_wr + 1'b1;
            end
            if (res_pop) begin
                r_res_rd <= r_res_rd + 1'b1;
            end
            case ({res_push, res_pop})
                2'b10:   r_res_cnt <= r_res_cnt + 1'b1;
                2'b01:   r_res_cnt <= r_res_cnt - 1'b1;
                default: r_res_cnt <= r_res_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/sync_header_frame_receiver.sv =====
// Top level of the double-sync, length-prefixed frame receiver
// Usage:
//   Input side is a queue write port: drive i_in_word and raise push; the word
//   is taken at a clock edge with push high and full low. op 0 carries a
//   received UART byte, op 1 reads one frame store byte, op 2 returns the
//   ready flag and clears it, op 3 does nothing but still yields a result.
//   Result side is a queue read port: while empty is low the oldest result
//   sits on o_out_word; raise pop to take it. Every input word gives one result.
//   A byte, take or idle word pushes its result when the engine pops it; a
//   store read first passes the registered store output, and a capturing
//   byte first runs the store copy through the one-byte-a-cycle buffer port.
//   The parser takes one word a cycle, while full is low, into a 4-entry
//   command queue; the engine retires one command a cycle while the result
//   queue has room, none in a read or copy: the sustained rate follows the mix.
//   Reset (synchronous, active low) empties both queues, clears the parser,
//   the ready flag and the valid bits, so both buffers read as zero at once.
//   A stalled receiver (pop low) holds results; once the 2-entry result
//   queue and the command queue fill, full rises and input words wait.
`timescale 1ns / 1ps
`default_nettype none

module sync_header_frame_receiver import shfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_word  i_in_word,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_out_word
);

    logic accept;      // input word taken this cycle
    t_cmd front_cmd;   // classified word from the parser
    t_cmd queue_cmd;   // oldest queued command
    logic cq_empty;
    logic cq_pop;

    assign accept = push && !full;

    // Parse headers and lengths, advance the byte index
    shfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_word (i_in_word),
        .o_cmd     (front_cmd)
    );

    // Hold parsed commands so the parser keeps taking words during a copy
    shfr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (cq_pop),
        .o_empty (cq_empty),
        .o_cmd   (queue_cmd)
    );

    // Store bytes, copy frames, serve reads and queue the results
    shfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cq_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (cq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ===== sv/shfr_checker.sv =====
// Port-level checker for the frame receiver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "sync_header_frame_receiver_defines.svh"

module shfr_checker import shfr_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input t_in_word  i_in_word,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_word o_out_word
);

    // Both queues come out of reset empty
    `SHFR_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> empty && !full)

    // A captured frame needs the flag clear before the byte
    `SHFR_ASSERT(a_cap_flag, i_clk, i_rst_n, !empty && o_out_word.frame_captured |-> !o_out_word.frame_ready)

    // A dropped frame means the flag was still set
    `SHFR_ASSERT(a_drop_flag, i_clk, i_rst_n, !empty && o_out_word.frame_dropped |-> o_out_word.frame_ready)

    // A waiting result holds until taken
    `SHFR_ASSERT(a_res_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_out_word))

endmodule

bind sync_header_frame_receiver shfr_checker u_shfr_checker (.*);

`default_nettype wire
